FILE: hdl/pack_delta_instruction_decoder_defines.svh
// Assertion macros shared by the delta decoder RTL.
// No dependencies; include by bare file name inside a module body.
`ifndef PACK_DELTA_INSTRUCTION_DECODER_DEFINES_SVH
`define PACK_DELTA_INSTRUCTION_DECODER_DEFINES_SVH

// Check a property on a given clock, disabled while the given reset is high.
`define PDID_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the block clock and reset.
`define PDID_ASSERT(lbl, prop, msg) \
   `PDID_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

FILE: hdl/pdid_pkg.sv
// Types and constants of the pack delta instruction decoder.
// No dependencies; imported by pack_delta_instruction_decoder.
package pdid_pkg;

   typedef enum logic [5:0] {
      PH_SKIP  = 6'b000001,
      PH_TGT   = 6'b000010,
      PH_OPC   = 6'b000100,
      PH_COPY  = 6'b001000,
      PH_INS   = 6'b010000,
      PH_DRAIN = 6'b100000
   } phase_type;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_LITERAL = 2'd0;
   localparam kind_type KIND_COPY    = 2'd1;
   localparam kind_type KIND_END     = 2'd2;

   localparam int SHIFT_W      = 6;
   localparam logic [SHIFT_W-1:0] SHIFT_BEYOND = 6'd62;
   localparam logic [SHIFT_W-1:0] SHIFT_TOP    = 6'd63;
   localparam logic [SHIFT_W:0]   SHIFT_STEP   = 7'd7;
   localparam int GROUP_W      = 71;

   localparam int OFFSET_W = 32;
   localparam int COUNT_W  = 24;
   localparam int FIELDS_W = 7;
   localparam logic [COUNT_W-1:0] COPY_DEFAULT = 24'h010000;

endpackage

FILE: hdl/pack_delta_instruction_decoder.sv
// Pack delta copy/insert instruction decoder, one delta byte per item.
// Depends on pdid_pkg and pack_delta_instruction_decoder_defines.svh.
//
// Accepts one delta byte per clock and gives its result in the next cycle from
// an output register; the next byte is taken while that result waits unless
// the result side stalls. Sustained rate, without stalls, is one byte per
// cycle, set by the update of the parse state (phase, remaining target size
// and copy field gathering) that each byte needs before the next can be decoded.
// A result appears for each literal byte, each finished copy descriptor and
// each last byte; a last byte with nothing to emit gives an end-status item.
module pack_delta_instruction_decoder
   import pdid_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] delta_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [7:0] literal_value, [39:8] source_offset,
                                    // [63:40] copy_count
   output logic [2:0]  rsp_tuser,   // [1:0] item_kind, [2] format_error
   output logic        rsp_tlast    // stream_done
);

`include "pack_delta_instruction_decoder_defines.svh"

   localparam int WIDE_W = (SIZE_BITS > COUNT_W) ? SIZE_BITS : COUNT_W;

   phase_type               phase_ff,  phase_in;
   logic [SIZE_BITS-1:0]    target_ff, target_in;
   logic [SHIFT_W-1:0]      shift_ff,  shift_in;
   logic [FIELDS_W-1:0]     mask_ff,   mask_in;
   logic [OFFSET_W-1:0]     offset_ff, offset_in;
   logic [COUNT_W-1:0]      length_ff, length_in;
   logic [6:0]              lits_ff,   lits_in;
   logic                    error_ff,  error_in;

   logic                    valid_ff;
   kind_type                kind_ff;
   logic [7:0]              lit_ff;
   logic [OFFSET_W-1:0]     off_ff;
   logic [COUNT_W-1:0]      cnt_ff;
   logic                    done_ff;
   logic                    ferr_ff;

   logic                    accept;
   logic [7:0]              b;
   logic [6:0]              payload;
   logic [GROUP_W-1:0]      group;
   logic                    group_over;
   logic [SHIFT_W:0]        shift_sum;
   logic [SHIFT_W-1:0]      shift_next;
   logic [2:0]              field_k;
   logic [FIELDS_W-1:0]     mask_next;
   logic [OFFSET_W-1:0]     offset_next;
   logic [COUNT_W-1:0]      length_next;
   logic                    do_finish;
   logic [COUNT_W-1:0]      fin_len;
   logic [OFFSET_W-1:0]     fin_off;
   logic [COUNT_W-1:0]      copy_n;
   logic [6:0]              lits_dec;
   logic                    fail;
   logic                    emit;
   kind_type                kind_o;
   logic [7:0]              lit_o;
   logic [OFFSET_W-1:0]     off_o;
   logic [COUNT_W-1:0]      cnt_o;
   logic                    end_error;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !valid_ff || rsp_tready;
   assign b          = req_tdata;
   assign payload    = b[6:0];

   // target size varint group placement and overflow
   assign group      = {{(GROUP_W-7){1'b0}}, payload} << shift_ff;
   assign group_over = (|group[GROUP_W-1:SIZE_BITS]) || (shift_ff == SHIFT_BEYOND);
   assign shift_sum  = {1'b0, shift_ff} + SHIFT_STEP;

   always_comb begin
      if (shift_ff == SHIFT_BEYOND || shift_sum > {1'b0, SHIFT_TOP}) begin
         shift_next = (shift_sum == {1'b0, SHIFT_TOP}) ? SHIFT_TOP : SHIFT_BEYOND;
      end else begin
         shift_next = shift_sum[SHIFT_W-1:0];
      end
   end

   // lowest pending copy field
   always_comb begin
      field_k = 3'd7;
      for (int i = FIELDS_W - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            field_k = 3'(i);
         end
      end
   end

   always_comb begin
      offset_next = offset_ff;
      length_next = length_ff;
      mask_next   = mask_ff & (mask_ff - 7'd1);
      case (field_k)
         3'd0: offset_next[7:0]   = offset_ff[7:0]   | b;
         3'd1: offset_next[15:8]  = offset_ff[15:8]  | b;
         3'd2: offset_next[23:16] = offset_ff[23:16] | b;
         3'd3: offset_next[31:24] = offset_ff[31:24] | b;
         3'd4: length_next[7:0]   = length_ff[7:0]   | b;
         3'd5: length_next[15:8]  = length_ff[15:8]  | b;
         3'd6: length_next[23:16] = length_ff[23:16] | b;
         default: mask_next = mask_ff;
      endcase
   end

   assign lits_dec = (lits_ff != 7'd0) ? lits_ff - 7'd1 : 7'd0;

   always_comb begin
      phase_in  = phase_ff;
      target_in = target_ff;
      shift_in  = shift_ff;
      mask_in   = mask_ff;
      offset_in = offset_ff;
      length_in = length_ff;
      lits_in   = lits_ff;
      error_in  = error_ff;
      fail      = 1'b0;
      emit      = 1'b0;
      do_finish = 1'b0;
      fin_len   = '0;
      fin_off   = '0;
      copy_n    = '0;
      kind_o    = KIND_END;
      lit_o     = '0;
      off_o     = '0;
      cnt_o     = '0;
      case (phase_ff)
         PH_SKIP: begin
            if (!b[7]) begin
               phase_in = PH_TGT;
            end
         end
         PH_TGT: begin
            if (payload != 7'd0 && group_over) begin
               fail = 1'b1;
            end else begin
               target_in = target_ff | group[SIZE_BITS-1:0];
               if (b[7]) begin
                  shift_in = shift_next;
               end else begin
                  phase_in = PH_OPC;
               end
            end
         end
         PH_OPC: begin
            if (b[7]) begin
               mask_in   = payload;
               offset_in = '0;
               length_in = '0;
               if (payload == 7'd0) begin
                  do_finish = 1'b1;
               end else begin
                  phase_in = PH_COPY;
               end
            end else if (b != 8'd0) begin
               if (WIDE_W'(b) > WIDE_W'(target_ff)) begin
                  fail = 1'b1;
               end else begin
                  target_in = target_ff - SIZE_BITS'(b);
                  lits_in   = payload;
                  phase_in  = PH_INS;
               end
            end
         end
         PH_COPY: begin
            mask_in   = mask_next;
            offset_in = offset_next;
            length_in = length_next;
            if (mask_next == 7'd0) begin
               do_finish = 1'b1;
               fin_len   = length_next;
               fin_off   = offset_next;
            end
         end
         PH_INS: begin
            emit    = 1'b1;
            kind_o  = KIND_LITERAL;
            lit_o   = b;
            lits_in = lits_dec;
            if (lits_dec == 7'd0) begin
               phase_in = PH_OPC;
            end
         end
         PH_DRAIN: begin
            phase_in = PH_DRAIN;
         end
         default: begin
            phase_in = PH_DRAIN;
         end
      endcase

      if (do_finish) begin
         copy_n = (fin_len != '0) ? fin_len : COPY_DEFAULT;
         if (WIDE_W'(copy_n) > WIDE_W'(target_ff)) begin
            fail = 1'b1;
         end else begin
            target_in = target_ff - SIZE_BITS'(copy_n);
            emit      = 1'b1;
            kind_o    = KIND_COPY;
            off_o     = fin_off;
            cnt_o     = copy_n;
            phase_in  = PH_OPC;
         end
      end

      if (fail) begin
         error_in = 1'b1;
         phase_in = PH_DRAIN;
      end
   end

   assign end_error = error_in || (phase_in != PH_OPC) || (target_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SKIP;
         target_ff <= '0;
         shift_ff  <= '0;
         mask_ff   <= '0;
         offset_ff <= '0;
         length_ff <= '0;
         lits_ff   <= '0;
         error_ff  <= 1'b0;
      end else if (accept) begin
         if (req_tlast) begin
            phase_ff  <= PH_SKIP;
            target_ff <= '0;
            shift_ff  <= '0;
            mask_ff   <= '0;
            offset_ff <= '0;
            length_ff <= '0;
            lits_ff   <= '0;
            error_ff  <= 1'b0;
         end else begin
            phase_ff  <= phase_in;
            target_ff <= target_in;
            shift_ff  <= shift_in;
            mask_ff   <= mask_in;
            offset_ff <= offset_in;
            length_ff <= length_in;
            lits_ff   <= lits_in;
            error_ff  <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept && (emit || req_tlast)) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (emit || req_tlast)) begin
         kind_ff <= kind_o;
         lit_ff  <= lit_o;
         off_ff  <= off_o;
         cnt_ff  <= cnt_o;
         done_ff <= req_tlast;
         ferr_ff <= req_tlast && end_error;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {cnt_ff, off_ff, lit_ff};
   assign rsp_tuser  = {ferr_ff, kind_ff};
   assign rsp_tlast  = done_ff;

   `PDID_ASSERT(a_error_only_at_end, valid_ff && ferr_ff |-> done_ff, "error flag without stream end")
   `PDID_ASSERT(a_status_only_at_end, valid_ff && kind_ff == KIND_END |-> done_ff, "end status item before stream end")
   `PDID_ASSERT(a_literal_clean, valid_ff && kind_ff == KIND_LITERAL |-> off_ff == '0 && cnt_ff == '0, "literal item carries copy fields")
   `PDID_ASSERT(a_copy_nonzero, valid_ff && kind_ff == KIND_COPY |-> cnt_ff != '0 && lit_ff == '0, "copy descriptor with zero count")
   `PDID_ASSERT(a_restart_after_last, accept && req_tlast |=> phase_ff == PH_SKIP && target_ff == '0 && !error_ff, "state not cleared after last byte")

endmodule
